>>> hdl/ipl4ck_pkg.sv
// Shared types, constants and offset decode functions for the IPv4 / TCP / UDP
// checksum engine. No dependencies.
`default_nettype none

package ipl4ck_pkg;

    // Checksum related constants
    localparam logic [15:0] UDP_ZERO_SUBST = 16'hFFFF;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [1:0]  KIND_NONE      = 2'd0;
    localparam logic [1:0]  KIND_TCP       = 2'd1;
    localparam logic [1:0]  KIND_UDP       = 2'd2;

    // Fixed byte offsets inside the IPv4 header
    localparam logic [15:0] OFF_VER_IHL    = 16'd0;
    localparam logic [15:0] OFF_LEN_HI     = 16'd2;
    localparam logic [15:0] OFF_LEN_LO     = 16'd3;
    localparam logic [15:0] OFF_PROTO      = 16'd9;
    localparam logic [15:0] OFF_CSUM_HI    = 16'd10;
    localparam logic [15:0] OFF_CSUM_LO    = 16'd11;
    localparam logic [15:0] OFF_LEN_END    = 16'd4;
    localparam logic [15:0] OFF_ADDR_FIRST = 16'd12;
    localparam logic [15:0] OFF_ADDR_LAST  = 16'd19;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;

    // Checksum field position relative to the L4 header
    localparam logic [6:0]  TCP_CSUM_REL   = 7'd16;
    localparam logic [6:0]  UDP_CSUM_REL   = 7'd6;

    // Sum widths: header covers at most 30 words, segment at most 32762 words
    localparam int HDR_SUM_W = 21;
    localparam int SEG_SUM_W = 31;

    typedef struct packed {
        logic [HDR_SUM_W-1:0] hdr_sum;
        logic [SEG_SUM_W-1:0] seg_sum;
        logic [16:0]          pseudo;     // protocol plus L4 length
        logic [1:0]           kind;
        logic                 short_pkt;
    } t_cap;

    // Byte at offset p counts toward the IPv4 header sum
    function automatic logic hdr_pred(input logic [15:0] p, input logic [5:0] hb,
                                      input logic [15:0] tl);
        logic in_hdr;
        in_hdr = (p < {10'd0, hb}) && (p != OFF_CSUM_HI) && (p != OFF_CSUM_LO);
        return in_hdr && ((p < OFF_LEN_END) || (p < tl));
    endfunction

    // Byte at offset p counts toward the pseudo-header plus segment sum
    function automatic logic seg_pred(input logic [15:0] p, input logic [5:0] hb,
                                      input logic [15:0] tl, input logic [7:0] proto);
        logic       addr;
        logic       body;
        logic [6:0] tcp_c;
        logic [6:0] udp_c;
        logic       skip;
        addr  = (p >= OFF_ADDR_FIRST) && (p <= OFF_ADDR_LAST);
        body  = (hb >= MIN_HDR_BYTES) && (p >= {10'd0, hb}) && (p < tl);
        tcp_c = {1'b0, hb} + TCP_CSUM_REL;
        udp_c = {1'b0, hb} + UDP_CSUM_REL;
        skip  = ((proto == PROTO_TCP) &&
                 ((p == {9'd0, tcp_c}) || (p == {9'd0, tcp_c + 7'd1}))) ||
                ((proto == PROTO_UDP) &&
                 ((p == {9'd0, udp_c}) || (p == {9'd0, udp_c + 7'd1})));
        return addr || (body && !skip);
    endfunction

endpackage

`default_nettype wire

>>> hdl/ipl4ck_if.sv
// Valid/ready channel interfaces for packet bytes and checksum results.
// Uses no package.
`default_nettype none

interface ipl4ck_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ipl4ck_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic [1:0]  l4_kind;
    logic        short_packet;

    modport source (output valid, output ip_checksum, output l4_checksum,
                    output l4_kind, output short_packet, input ready);
    modport sink   (input valid, input ip_checksum, input l4_checksum,
                    input l4_kind, input short_packet, output ready);
endinterface

`default_nettype wire

>>> hdl/ipl4ck_accum.sv
// Byte input register and per-packet accumulator: parses header fields and
// sums header and segment words. Depends on ipl4ck_pkg and ipl4ck_byte_if.
`default_nettype none

module ipl4ck_accum
    import ipl4ck_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ipl4ck_byte_if.sink i_byte,
    output t_cap        o_cap,
    output logic        o_cap_valid,
    input  wire logic   i_cap_ready
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;

    logic [15:0]          r_offset;
    logic [5:0]           r_hdr_bytes;
    logic [15:0]          r_total_len;
    logic [7:0]           r_proto;
    logic [HDR_SUM_W-1:0] r_hdr_sum;
    logic [SEG_SUM_W-1:0] r_seg_sum;
    logic [7:0]           r_held;

    logic                 r_cap_valid;
    t_cap                 r_cap;

    logic                 cap_can_load;
    logic                 consume;
    logic [5:0]           eff_hb;
    logic [15:0]          eff_tl;
    logic [7:0]           eff_proto;
    logic                 odd;
    logic [15:0]          off_even;
    logic [7:0]           hi_byte;
    logic                 hdr_hi_en;
    logic                 hdr_lo_en;
    logic                 seg_hi_en;
    logic                 seg_lo_en;
    logic [15:0]          hdr_add;
    logic [15:0]          seg_add;
    logic [HDR_SUM_W-1:0] hdr_sum_nx;
    logic [SEG_SUM_W-1:0] seg_sum_nx;
    logic [1:0]           kind;
    logic [15:0]          l4_len;
    t_cap                 n_cap;

    assign cap_can_load = !r_cap_valid || i_cap_ready;
    assign consume      = r_in_valid && (!r_in_last || cap_can_load);
    assign i_byte.ready = !r_in_valid || consume;

    // Header fields as they stand after this byte
    always_comb begin
        eff_hb    = r_hdr_bytes;
        eff_tl    = r_total_len;
        eff_proto = r_proto;
        case (r_offset)
            OFF_VER_IHL: eff_hb    = {r_in_byte[3:0], 2'b00};
            OFF_LEN_HI:  eff_tl    = {r_in_byte, 8'h00};
            OFF_LEN_LO:  eff_tl    = {r_total_len[15:8], r_in_byte};
            OFF_PROTO:   eff_proto = r_in_byte;
            default:     ;
        endcase
    end

    // One 16-bit addend per sum: high byte at the even offset, low byte at the odd one.
    // A last byte at an even offset pads as a high byte.
    assign odd       = r_offset[0];
    assign off_even  = {r_offset[15:1], 1'b0};
    assign hi_byte   = odd ? r_held : r_in_byte;
    assign hdr_hi_en = (odd || r_in_last) && hdr_pred(off_even, eff_hb, eff_tl);
    assign hdr_lo_en = odd && hdr_pred(r_offset, eff_hb, eff_tl);
    assign seg_hi_en = (odd || r_in_last) && seg_pred(off_even, eff_hb, eff_tl, eff_proto);
    assign seg_lo_en = odd && seg_pred(r_offset, eff_hb, eff_tl, eff_proto);
    assign hdr_add   = {hdr_hi_en ? hi_byte : 8'h00, hdr_lo_en ? r_in_byte : 8'h00};
    assign seg_add   = {seg_hi_en ? hi_byte : 8'h00, seg_lo_en ? r_in_byte : 8'h00};

    assign hdr_sum_nx = r_hdr_sum + {{(HDR_SUM_W-16){1'b0}}, hdr_add};
    assign seg_sum_nx = r_seg_sum + {{(SEG_SUM_W-16){1'b0}}, seg_add};

    always_comb begin
        kind = KIND_NONE;
        if (eff_hb >= MIN_HDR_BYTES) begin
            if (eff_proto == PROTO_TCP) begin
                kind = KIND_TCP;
            end else if (eff_proto == PROTO_UDP) begin
                kind = KIND_UDP;
            end
        end
    end

    assign l4_len          = eff_tl - {10'd0, eff_hb};
    assign n_cap.hdr_sum   = hdr_sum_nx;
    assign n_cap.seg_sum   = seg_sum_nx;
    assign n_cap.pseudo    = {9'd0, eff_proto} + {1'b0, l4_len};
    assign n_cap.kind      = kind;
    assign n_cap.short_pkt = ({1'b0, r_offset} + 17'd1) < {1'b0, eff_tl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cap_valid <= 1'b0;
            r_offset    <= '0;
            r_hdr_bytes <= '0;
            r_total_len <= '0;
            r_proto     <= '0;
            r_hdr_sum   <= '0;
            r_seg_sum   <= '0;
            r_held      <= '0;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            if (consume && r_in_last) begin
                r_cap_valid <= 1'b1;
            end else if (i_cap_ready) begin
                r_cap_valid <= 1'b0;
            end

            if (consume) begin
                if (r_in_last) begin
                    // clear for the next packet
                    r_offset    <= '0;
                    r_hdr_bytes <= '0;
                    r_total_len <= '0;
                    r_proto     <= '0;
                    r_hdr_sum   <= '0;
                    r_seg_sum   <= '0;
                    r_held      <= '0;
                end else begin
                    if (r_offset != OFFSET_MAX) begin
                        r_offset <= r_offset + 16'd1;
                    end
                    r_hdr_bytes <= eff_hb;
                    r_total_len <= eff_tl;
                    r_proto     <= eff_proto;
                    r_hdr_sum   <= hdr_sum_nx;
                    r_seg_sum   <= seg_sum_nx;
                    r_held      <= odd ? 8'h00 : r_in_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last;
        end
        if (consume && r_in_last) begin
            r_cap <= n_cap;
        end
    end

    assign o_cap       = r_cap;
    assign o_cap_valid = r_cap_valid;

endmodule

`default_nettype wire

>>> hdl/ipl4ck_fold.sv
// Two-stage fold and invert of the captured sums into the result register.
// Depends on ipl4ck_pkg and ipl4ck_result_if.
`default_nettype none

module ipl4ck_fold
    import ipl4ck_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cap         i_cap,
    input  wire logic         i_cap_valid,
    output logic              o_cap_ready,
    ipl4ck_result_if.source   o_result
);

    logic        r_mid_valid;
    logic [16:0] r_hdr_f1;
    logic [31:0] r_seg_tot;
    logic [1:0]  r_mid_kind;
    logic        r_mid_short;

    logic        r_out_valid;
    logic [15:0] r_ip;
    logic [15:0] r_l4;
    logic [1:0]  r_kind;
    logic        r_short;

    logic        out_can_load;
    logic        mid_can_load;
    logic        mid_load;
    logic        out_load;
    logic [15:0] hdr_f2;
    logic [16:0] seg_f1;
    logic [15:0] seg_f2;
    logic [15:0] l4_inv;
    logic [15:0] n_l4;

    assign out_can_load = !r_out_valid || o_result.ready;
    assign mid_can_load = !r_mid_valid || out_can_load;
    assign o_cap_ready  = mid_can_load;
    assign mid_load     = i_cap_valid && mid_can_load;
    assign out_load     = r_mid_valid && out_can_load;

    // Second fold needs only the carry bit added back in
    assign hdr_f2 = r_hdr_f1[15:0] + {15'd0, r_hdr_f1[16]};
    assign seg_f1 = {1'b0, r_seg_tot[31:16]} + {1'b0, r_seg_tot[15:0]};
    assign seg_f2 = seg_f1[15:0] + {15'd0, seg_f1[16]};
    assign l4_inv = ~seg_f2;

    always_comb begin
        case (r_mid_kind)
            KIND_TCP: n_l4 = l4_inv;
            KIND_UDP: n_l4 = (l4_inv == 16'h0000) ? UDP_ZERO_SUBST : l4_inv;
            default:  n_l4 = 16'h0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mid_can_load) begin
                r_mid_valid <= i_cap_valid;
            end
            if (out_can_load) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_load) begin
            r_hdr_f1    <= {1'b0, 11'd0, i_cap.hdr_sum[HDR_SUM_W-1:16]}
                           + {1'b0, i_cap.hdr_sum[15:0]};
            r_seg_tot   <= {1'b0, i_cap.seg_sum} + {15'd0, i_cap.pseudo};
            r_mid_kind  <= i_cap.kind;
            r_mid_short <= i_cap.short_pkt;
        end
        if (out_load) begin
            r_ip    <= ~hdr_f2;
            r_l4    <= n_l4;
            r_kind  <= r_mid_kind;
            r_short <= r_mid_short;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.ip_checksum  = r_ip;
    assign o_result.l4_checksum  = r_l4;
    assign o_result.l4_kind      = r_kind;
    assign o_result.short_packet = r_short;

endmodule

`default_nettype wire

>>> hdl/ipv4_l4_checksum_offload.sv
// Top level of the IPv4 header and TCP/UDP checksum engine.
// Depends on ipl4ck_pkg, ipl4ck_if, ipl4ck_accum and ipl4ck_fold.
//
// Feed an IPv4 packet one byte per item in network order on i_byte, with last
// set on its final byte. While i_byte.ready is high the block takes one byte
// every clock cycle with no gaps, also across packet boundaries: the first
// byte of the next packet may follow the last byte of the previous one
// directly. Each packet yields one result item on o_result: the last byte
// passes the input register, is summed in the accumulator into the capture
// register, is folded once in the middle stage and folded again and inverted
// into the output register. A result that waits on o_result.ready does not
// stall byte intake; only a packet end that reaches the accumulator while
// the capture, middle and output stages are all full and o_result.ready is
// low holds i_byte.ready low.
// The result carries the IPv4 header checksum (checksum field taken as zero),
// the TCP or UDP checksum with pseudo-header (zero when l4_kind is other; a
// UDP value of zero is sent as 0xFFFF) and a flag for a packet that ended
// before its total length. Bytes past the total length are ignored, and the
// packet is not modified.
`default_nettype none

module ipv4_l4_checksum_offload
    import ipl4ck_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ipl4ck_byte_if.sink     i_byte,
    ipl4ck_result_if.source o_result
);

    t_cap cap;
    logic cap_valid;
    logic cap_ready;

    // Parse and accumulate one byte per cycle unless a packet end waits on a full fold stage
    ipl4ck_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_cap       (cap),
        .o_cap_valid (cap_valid),
        .i_cap_ready (cap_ready)
    );

    // Fold, invert and present the packet result
    ipl4ck_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (cap),
        .i_cap_valid (cap_valid),
        .o_cap_ready (cap_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
